### design/heap_sorter_unit_assert.svh
// Assertion macros for the heap sorter checker.
`ifndef HEAP_SORTER_UNIT_ASSERT_SVH
`define HEAP_SORTER_UNIT_ASSERT_SVH

// Plain property, clocked on the rising edge, off during reset.
`define HSU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("heap sorter assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define HSU_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("heap sorter assertion failed");

`endif

### design/hsu_pkg.sv
// Types and constants of the heap sorter unit.
`timescale 1ns / 1ps
`default_nettype none

package hsu_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### design/hsu_cell.sv
// One sorting cell: keeps the smaller word, passes the larger one onward.
`timescale 1ns / 1ps
`default_nettype none

module hsu_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic          in_valid,
	input  wire hsu_pkg::word_t in_value,
	input  wire logic          nb_valid,
	input  wire hsu_pkg::word_t nb_value,
	output logic               held_valid,
	output hsu_pkg::word_t     held_value,
	output logic               pass_valid,
	output hsu_pkg::word_t     pass_value
);
	import hsu_pkg::*;

	logic  held_valid_q;
	word_t held_value_q;
	logic  pass_valid_q;
	word_t pass_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (shift) begin
			held_valid_q <= nb_valid;
			pass_valid_q <= 1'b0;
		end else if (in_valid) begin
			held_valid_q <= 1'b1;
			pass_valid_q <= held_valid_q;
		end else begin
			pass_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			held_value_q <= nb_value;
		end else if (in_valid) begin
			if (!held_valid_q || (in_value < held_value_q)) begin
				held_value_q <= in_value;
				pass_value_q <= held_value_q;
			end else begin
				pass_value_q <= in_value;
			end
		end
	end

	assign held_valid = held_valid_q;
	assign held_value = held_value_q;
	assign pass_valid = pass_valid_q;
	assign pass_value = pass_value_q;

endmodule

`default_nettype wire

### design/heap_sorter_unit.sv
// Top level of the heap sorter unit: cell chain and run control.
// Usage:
//   Slave channel s_*: one word per value, tdata = value, tlast closes the set.
//   Master channel m_*: one word per stored value, smallest first;
//   tdata = sorted_value, tlast = final_res, tuser = overflow.
//   Up to MAX_ITEMS values are held; further values of the set are dropped
//   and every result of that run carries overflow = 1.
// Run sequence:
//   Input words are taken only while s_tready is high; the chain of MAX_ITEMS
//   cells sorts each word while the next word arrives. After the word marked
//   last, s_tready drops and the block waits until no cell passes a word on,
//   then loads the results from the head cell, one per cycle while m_tready
//   is high, shifting the chain toward the head. After the final result is
//   loaded the block is ready for the next set.
// Reset: clears the cell valid bits, the count, the drop flag and the
//   output valid; the block comes up ready for a new set.
// Stall: a held result stays on m_* and the chain holds until taken.
`timescale 1ns / 1ps
`default_nettype none

module heap_sorter_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] sorted_value
	output logic             m_tlast,
	output logic             m_tuser    // [0] overflow
);
	import hsu_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	state_t     state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic       dropped_q;
	logic       accept, inject, advance, settled;

	logic       m_tvalid_q;
	word_t      m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;

	logic       held_v [MAX_ITEMS];
	word_t      held_d [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] pass_v;
	word_t      pass_d [MAX_ITEMS];

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			logic  in_v, nb_v;
			word_t in_d, nb_d;
			if (gi == 0) begin : g_head
				assign in_v = inject;
				assign in_d = word_t'(s_tdata);
			end else begin : g_mid
				assign in_v = pass_v[gi-1];
				assign in_d = pass_d[gi-1];
			end
			if (gi == MAX_ITEMS - 1) begin : g_tail
				assign nb_v = 1'b0;
				assign nb_d = '0;
				hsu_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift      (advance),
					.in_valid   (in_v),
					.in_value   (in_d),
					.nb_valid   (nb_v),
					.nb_value   (nb_d),
					.held_valid (held_v[gi]),
					.held_value (held_d[gi]),
					.pass_valid (pass_v[gi]),
					.pass_value (pass_d[gi])
				);
			end else begin : g_body
				assign nb_v = held_v[gi+1];
				assign nb_d = held_d[gi+1];
				hsu_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift      (advance),
					.in_valid   (in_v),
					.in_value   (in_d),
					.nb_valid   (nb_v),
					.nb_value   (nb_d),
					.held_valid (held_v[gi]),
					.held_value (held_d[gi]),
					.pass_valid (pass_v[gi]),
					.pass_value (pass_d[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		s_tready = (state_q == ST_FILL);
		accept   = s_tvalid && s_tready;
		inject   = accept && (count_q < CNT_W'(MAX_ITEMS));
		advance  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
		settled  = ~|pass_v;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (accept && s_tlast) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (settled) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (advance && (count_q == CNT_W'(1))) state_d = ST_FILL;
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (inject) begin
				count_q <= count_q + CNT_W'(1);
			end else if (advance) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept && !inject) begin
				dropped_q <= 1'b1;
			end else if (advance && (count_q == CNT_W'(1))) begin
				dropped_q <= 1'b0;
			end
			if (advance) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= held_d[0];
			m_tlast_q <= (count_q == CNT_W'(1));
			m_tuser_q <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 32'(m_tdata_q);
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

### design/heap_sorter_unit_chk.sv
// Port-level checker of the heap sorter unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "heap_sorter_unit_assert.svh"

module heap_sorter_unit_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	`HSU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`HSU_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`HSU_ASSERT_NEXT(a_close_set, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready)
	`HSU_ASSERT(a_run_blocks_in, clk, arst_n, !(m_tvalid && !m_tlast && s_tready))

endmodule

bind heap_sorter_unit heap_sorter_unit_chk u_chk (.*);

`default_nettype wire

### tb/heap_sorter_unit_test.sv
// Testbench for the heap sorter unit: directed table, random sets, scoreboard of sorted words.
`timescale 1ns / 1ps

module heap_sorter_unit_test;
	import hsu_pkg::*;

	localparam int CAP = 64;
	localparam int ITEMS = 250;
	localparam int IDLE_PCT = 19;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 2 * CAP + 20;
	localparam int STALL_LIMIT = 5000;
	localparam word_t W_MIN = 32'sh8000_0000;
	localparam word_t W_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		word_t value;
		logic  final_res;
		logic  overflow;
	} sorted_word_t;

	typedef struct packed {
		word_t        value;
		logic         last;
		logic         typed;
		sorted_word_t exp;
	} stim_row_t;

	localparam int N_ROWS = 19;
	localparam stim_row_t DIR_TABLE [N_ROWS] = '{
		'{W_MIN, 1'b1, 1'b1, '{W_MIN, 1'b1, 1'b0}},
		'{W_MAX, 1'b1, 1'b1, '{W_MAX, 1'b1, 1'b0}},
		'{32'sd0, 1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
		'{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
		'{W_MAX, 1'b0, 1'b0, '0},
		'{W_MIN, 1'b0, 1'b0, '0},
		'{32'sd0, 1'b0, 1'b0, '0},
		'{-32'sd1, 1'b0, 1'b0, '0},
		'{32'sd1, 1'b0, 1'b0, '0},
		'{32'sh5555_5555, 1'b0, 1'b0, '0},
		'{32'shaaaa_aaaa, 1'b0, 1'b0, '0},
		'{32'sd5, 1'b0, 1'b0, '0},
		'{32'sd5, 1'b0, 1'b0, '0},
		'{32'sd2, 1'b1, 1'b0, '0},
		'{32'sd7, 1'b0, 1'b0, '0},
		'{-32'sd7, 1'b1, 1'b0, '0},
		'{32'sd3, 1'b0, 1'b0, '0},
		'{32'sd3, 1'b0, 1'b0, '0},
		'{32'sd3, 1'b1, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	sorted_word_t sorted_words [$];
	word_t        open_set [$];
	logic         set_dropped = 1'b0;
	logic         quiet = 1'b0;
	logic         hold_req = 1'b0;
	int           errors = 0;
	int           words_sent = 0;
	int           sets_closed = 0;
	int           overflow_sets = 0;
	int           biggest_set = 0;
	int           results_seen = 0;

	heap_sorter_unit #(.MAX_ITEMS(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Store one value into the open set; on the closing word sort it, queue the run if emit.
	task automatic absorb_word(input word_t v, input logic closing, input logic emit);
		int    i;
		int    j;
		word_t key;
		if (open_set.size() < CAP)
			open_set.push_back(v);
		else
			set_dropped = 1'b1;
		if (closing) begin
			for (i = 1; i < open_set.size(); i++) begin
				key = open_set[i];
				j = i;
				while (j > 0 && open_set[j-1] > key) begin
					open_set[j] = open_set[j-1];
					j--;
				end
				open_set[j] = key;
			end
			if (emit)
				for (i = 0; i < open_set.size(); i++)
					sorted_words.push_back('{open_set[i], i == open_set.size() - 1, set_dropped});
			sets_closed++;
			if (set_dropped)
				overflow_sets++;
			if (open_set.size() > biggest_set)
				biggest_set = open_set.size();
			open_set.delete();
			set_dropped = 1'b0;
		end
	endtask

	task automatic send_word(input word_t v, input logic closing, input logic typed,
			input sorted_word_t exp);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= closing;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		absorb_word(v, closing, !typed);
		if (typed)
			sorted_words.push_back(exp);
	endtask

	function automatic word_t next_value();
		case ($urandom_range(9))
			5, 6: next_value = $signed($urandom_range(8)) - 4;
			7: next_value = $urandom_range(1) ? W_MAX : W_MIN;
			8: next_value = $signed($urandom_range(2000)) - 1000;
			default: next_value = $urandom;
		endcase
	endfunction

	initial begin : stimulus
		int set_idx;
		int set_size;
		int k;
		do @(posedge clk); while (arst_n !== 1'b1);
		for (k = 0; k < N_ROWS; k++)
			send_word(DIR_TABLE[k].value, DIR_TABLE[k].last, DIR_TABLE[k].typed,
				DIR_TABLE[k].exp);
		// full store, closing word dropped
		for (k = 0; k <= CAP; k++)
			send_word(next_value(), k == CAP, 1'b0, '0);
		set_idx = 0;
		while (words_sent < ITEMS) begin
			quiet = (set_idx >= 6 && set_idx <= 10);
			set_size = $urandom_range(1, 12);
			if (set_idx == 1) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sorted_words.size() != 0);
				hold_req = 1'b1;
				set_size = CAP;
			end else if (set_idx == 4) begin
				set_size = CAP + $urandom_range(1, 4);
			end
			for (k = 0; k < set_size; k++)
				send_word(next_value(), k == set_size - 1, 1'b0, '0);
			set_idx++;
		end
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sorted_words.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d words in %0d sets (largest %0d, %0d with dropped values).",
			words_sent, sets_closed, biggest_set, overflow_sets);
		$display("Checked %0d sorted words, %0d mismatches.", results_seen, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : sink
		int           hold_left;
		sorted_word_t e;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (sorted_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word value %0d last %0b overflow %0b", $time,
						$signed(m_tdata), m_tlast, m_tuser);
				end else begin
					e = sorted_words.pop_front();
					if (m_tdata !== e.value || m_tlast !== e.final_res || m_tuser !== e.overflow) begin
						errors++;
						$display("%0t: expected %0d/%0b/%0b got %0d/%0b/%0b", $time, e.value,
							e.final_res, e.overflow, $signed(m_tdata), m_tlast, m_tuser);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled = 0;
			else
				stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
